// ===== sv/nrte_pkg.sv =====
// Package for the NMEA RMC time extractor: field widths, character codes,
// and small helpers (ID characters, hex and decimal digits, modulo-24 reduction).
// No dependencies.
package nrte_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned OFFSET_W = 5;
	localparam int unsigned HOURS_W  = 5;
	localparam int unsigned MINSEC_W = 7;
	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned FIELD_W  = 5;
	localparam int unsigned CHAR_W   = 4;
	localparam int unsigned HEXCNT_W = 2;
	localparam int unsigned TIME_DIGITS = 6;
	localparam int unsigned ID_LEN      = 6;

	localparam logic [OFFSET_W-1:0] HOUR_OFFSET_RST = 5'd8;
	localparam logic [FIELD_W-1:0]  FIELD_MAX       = 5'd31;
	localparam logic [CHAR_W-1:0]   CHAR_MAX        = 4'd15;
	localparam logic [HEXCNT_W-1:0] HEXCNT_MAX      = 2'd3;
	localparam logic [HEXCNT_W-1:0] HEXCNT_FULL     = 2'd2;
	localparam logic [7:0]          HOURS_PER_DAY   = 8'd24;

	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
	localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UPPER_F = 8'h46;

	typedef logic [DIGIT_W-1:0] digit_t;

	typedef struct packed {
		logic                is_rmc;
		logic                position_fixed;
		logic                checksum_ok;
		logic                sentence_valid;
		logic [HOURS_W-1:0]  local_hours;
		logic [MINSEC_W-1:0] minutes;
		logic [MINSEC_W-1:0] seconds;
	} result_t;

	// Expected character of the sentence ID at a given position
	function automatic logic [BYTE_W-1:0] id_char(input logic [2:0] pos);
		logic [BYTE_W-1:0] c;
		case (pos)
			3'd0: c = CH_DOLLAR;
			3'd1: c = 8'h47;
			3'd2: c = 8'h50;
			3'd3: c = 8'h52;
			3'd4: c = 8'h4D;
			3'd5: c = 8'h43;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_dec(input logic [BYTE_W-1:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_hex_letter(input logic [BYTE_W-1:0] b);
		return (b >= CH_UPPER_A) && (b <= CH_UPPER_F);
	endfunction

	function automatic digit_t hex_value(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] d;
		d = is_dec(b) ? (b - CH_ZERO) : (b - CH_UPPER_A + 8'd10);
		return d[DIGIT_W-1:0];
	endfunction

	function automatic logic [MINSEC_W-1:0] two_digits(input digit_t hi, input digit_t lo);
		logic [MINSEC_W-1:0] h;
		h = {hi, 3'b000} + {2'b00, hi, 1'b0};
		return h + {3'b000, lo};
	endfunction

	// Sum stays below 6 * 24, so five conditional subtractions reduce it
	function automatic logic [HOURS_W-1:0] mod24(input logic [7:0] s);
		logic [7:0] r;
		r = s;
		for (int i = 0; i < 5; i++) begin
			if (r >= HOURS_PER_DAY) begin
				r = r - HOURS_PER_DAY;
			end
		end
		return r[HOURS_W-1:0];
	endfunction

endpackage

// ===== sv/nrte_if.sv =====
// Channel interfaces for the NMEA RMC time extractor: character input and
// time report output. Depends on nrte_pkg.
interface nrte_char_if;
	logic                       valid;
	logic                       ready;
	logic [nrte_pkg::BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface nrte_time_if;
	logic                          valid;
	logic                          ready;
	logic                          is_rmc;
	logic                          position_fixed;
	logic                          checksum_ok;
	logic                          sentence_valid;
	logic [nrte_pkg::HOURS_W-1:0]  local_hours;
	logic [nrte_pkg::MINSEC_W-1:0] minutes;
	logic [nrte_pkg::MINSEC_W-1:0] seconds;

	modport source (output valid, output is_rmc, output position_fixed,
		output checksum_ok, output sentence_valid, output local_hours,
		output minutes, output seconds, input ready);
	modport sink (input valid, input is_rmc, input position_fixed,
		input checksum_ok, input sentence_valid, input local_hours,
		input minutes, input seconds, output ready);
endinterface

// ===== sv/nmea_rmc_time_extractor_core.sv =====
// Top level of the NMEA RMC time extractor: input byte register, sentence
// parser state, and a time report register. Depends on nrte_pkg and nrte_if.
//
//   channel       dir  payload                                  transfer
//   char_stream   in   in_byte                                  valid & ready
//   time_report   out  flags, local_hours, minutes, seconds     valid & ready
//   cfg           in   hour_offset (cfg_wr_data)                cfg_wr_en
//
// One byte per cycle while char_stream is not stalled; a byte is held in the input
// register, and a line feed's report is loaded into the output register from it.
// Reset sets hour_offset to 8 and resets all sentence state.
// char_stream stalls only when a sentence-ending line feed waits in the input register while
// an untaken report still fills the output register.
module nmea_rmc_time_extractor_core (
	input  logic                           clk,
	input  logic                           arst_n,
	nrte_char_if.sink                      char_stream,
	nrte_time_if.source                    time_report,
	input  logic                           cfg_wr_en,
	input  logic [nrte_pkg::OFFSET_W-1:0]  cfg_wr_data
);

	logic [nrte_pkg::OFFSET_W-1:0] hour_offset_q;

	logic                          valid_s1;
	logic [nrte_pkg::BYTE_W-1:0]   byte_s1;

	logic                          in_sentence_q, in_sentence_d;
	logic [nrte_pkg::BYTE_W-1:0]   running_xor_q, running_xor_d;
	logic [nrte_pkg::FIELD_W-1:0]  field_number_q, field_number_d;
	logic [nrte_pkg::CHAR_W-1:0]   char_in_field_q, char_in_field_d;
	logic                          id_matches_q, id_matches_d;
	logic                          status_is_a_q, status_is_a_d;
	logic                          after_star_q, after_star_d;
	logic [nrte_pkg::HEXCNT_W-1:0] hex_digit_count_q, hex_digit_count_d;
	logic [nrte_pkg::BYTE_W-1:0]   received_sum_q, received_sum_d;
	logic                          hex_bad_q, hex_bad_d;
	nrte_pkg::digit_t              time_digits_q [nrte_pkg::TIME_DIGITS];
	nrte_pkg::digit_t              time_digits_d [nrte_pkg::TIME_DIGITS];

	logic                          emit_s1;
	logic                          out_free;
	logic                          s1_go;
	logic                          s1_fire;
	nrte_pkg::result_t             result_d;
	nrte_pkg::result_t             result_q;
	logic                          out_valid_q;

	logic                          rmc_flag;
	logic                          ck_flag;
	logic [nrte_pkg::MINSEC_W-1:0] utc_hours;

	assign emit_s1  = valid_s1 && in_sentence_q && (byte_s1 == nrte_pkg::CH_LF);
	assign out_free = !out_valid_q || time_report.ready;
	assign s1_go    = !emit_s1 || out_free;
	assign s1_fire  = valid_s1 && s1_go;
	assign char_stream.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_offset_q <= nrte_pkg::HOUR_OFFSET_RST;
		end else if (cfg_wr_en) begin
			hour_offset_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_stream.ready) begin
			valid_s1 <= char_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_stream.ready && char_stream.valid) begin
			byte_s1 <= char_stream.in_byte;
		end
	end

	assign rmc_flag  = id_matches_q && (field_number_q != '0);
	assign ck_flag   = after_star_q && !hex_bad_q && (hex_digit_count_q == nrte_pkg::HEXCNT_FULL)
		&& (received_sum_q == running_xor_q);
	assign utc_hours = nrte_pkg::two_digits(time_digits_q[0], time_digits_q[1]);

	always_comb begin
		result_d.is_rmc         = rmc_flag;
		result_d.position_fixed = status_is_a_q;
		result_d.checksum_ok    = ck_flag;
		result_d.sentence_valid = rmc_flag && status_is_a_q && ck_flag;
		result_d.local_hours    = nrte_pkg::mod24({1'b0, utc_hours} + {3'b000, hour_offset_q});
		result_d.minutes        = nrte_pkg::two_digits(time_digits_q[2], time_digits_q[3]);
		result_d.seconds        = nrte_pkg::two_digits(time_digits_q[4], time_digits_q[5]);
	end

	always_comb begin
		in_sentence_d     = in_sentence_q;
		running_xor_d     = running_xor_q;
		field_number_d    = field_number_q;
		char_in_field_d   = char_in_field_q;
		id_matches_d      = id_matches_q;
		status_is_a_d     = status_is_a_q;
		after_star_d      = after_star_q;
		hex_digit_count_d = hex_digit_count_q;
		received_sum_d    = received_sum_q;
		hex_bad_d         = hex_bad_q;
		time_digits_d     = time_digits_q;

		if (s1_fire) begin
			if (byte_s1 == nrte_pkg::CH_DOLLAR || emit_s1) begin
				// restart on '$', drop everything on line feed
				in_sentence_d     = (byte_s1 == nrte_pkg::CH_DOLLAR);
				running_xor_d     = '0;
				field_number_d    = '0;
				char_in_field_d   = (byte_s1 == nrte_pkg::CH_DOLLAR) ? 4'd1 : 4'd0;
				id_matches_d      = 1'b1;
				status_is_a_d     = 1'b0;
				after_star_d      = 1'b0;
				hex_digit_count_d = '0;
				received_sum_d    = '0;
				hex_bad_d         = 1'b0;
				for (int i = 0; i < nrte_pkg::TIME_DIGITS; i++) begin
					time_digits_d[i] = '0;
				end
			end else if (in_sentence_q && byte_s1 != nrte_pkg::CH_CR) begin
				if (after_star_q) begin
					if (nrte_pkg::is_dec(byte_s1) || nrte_pkg::is_hex_letter(byte_s1)) begin
						received_sum_d = {received_sum_q[3:0], nrte_pkg::hex_value(byte_s1)};
						if (hex_digit_count_q != nrte_pkg::HEXCNT_MAX) begin
							hex_digit_count_d = hex_digit_count_q + 2'd1;
						end
					end else begin
						hex_bad_d = 1'b1;
					end
				end else if (byte_s1 == nrte_pkg::CH_STAR) begin
					after_star_d = 1'b1;
				end else begin
					running_xor_d = running_xor_q ^ byte_s1;
					if (byte_s1 == nrte_pkg::CH_COMMA) begin
						if (field_number_q == '0 && char_in_field_q != 4'd6) begin
							id_matches_d = 1'b0;
						end
						if (field_number_q != nrte_pkg::FIELD_MAX) begin
							field_number_d = field_number_q + 5'd1;
						end
						char_in_field_d = '0;
					end else begin
						case (field_number_q)
							5'd0: begin
								if (char_in_field_q >= 4'd6 ||
									byte_s1 != nrte_pkg::id_char(char_in_field_q[2:0])) begin
									id_matches_d = 1'b0;
								end
							end
							5'd1: begin
								if (char_in_field_q < 4'd6) begin
									time_digits_d[char_in_field_q[2:0]] =
										nrte_pkg::is_dec(byte_s1) ?
										nrte_pkg::hex_value(byte_s1) : '0;
								end
							end
							5'd2: begin
								if (char_in_field_q == '0) begin
									status_is_a_d = (byte_s1 == nrte_pkg::CH_UPPER_A);
								end
							end
							default: begin
							end
						endcase
						if (char_in_field_q != nrte_pkg::CHAR_MAX) begin
							char_in_field_d = char_in_field_q + 4'd1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sentence_q     <= 1'b0;
			running_xor_q     <= '0;
			field_number_q    <= '0;
			char_in_field_q   <= '0;
			id_matches_q      <= 1'b1;
			status_is_a_q     <= 1'b0;
			after_star_q      <= 1'b0;
			hex_digit_count_q <= '0;
			received_sum_q    <= '0;
			hex_bad_q         <= 1'b0;
			for (int i = 0; i < nrte_pkg::TIME_DIGITS; i++) begin
				time_digits_q[i] <= '0;
			end
		end else begin
			in_sentence_q     <= in_sentence_d;
			running_xor_q     <= running_xor_d;
			field_number_q    <= field_number_d;
			char_in_field_q   <= char_in_field_d;
			id_matches_q      <= id_matches_d;
			status_is_a_q     <= status_is_a_d;
			after_star_q      <= after_star_d;
			hex_digit_count_q <= hex_digit_count_d;
			received_sum_q    <= received_sum_d;
			hex_bad_q         <= hex_bad_d;
			time_digits_q     <= time_digits_d;
		end
	end

	// Report register: load on a line feed, hold until the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_fire && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_fire && emit_s1) begin
			result_q <= result_d;
		end
	end

	assign time_report.valid          = out_valid_q;
	assign time_report.is_rmc         = result_q.is_rmc;
	assign time_report.position_fixed = result_q.position_fixed;
	assign time_report.checksum_ok    = result_q.checksum_ok;
	assign time_report.sentence_valid = result_q.sentence_valid;
	assign time_report.local_hours    = result_q.local_hours;
	assign time_report.minutes        = result_q.minutes;
	assign time_report.seconds        = result_q.seconds;

endmodule
